@@ design/froxel_fog_column_integrator_assert.svh @@
// Assertion macros for the froxel fog column integrator.
// Each macro expects clk and arst_n in scope.
`ifndef FROXEL_FOG_COLUMN_INTEGRATOR_ASSERT_SVH
`define FROXEL_FOG_COLUMN_INTEGRATOR_ASSERT_SVH

// same-cycle implication
`define FFCI_ASSERT_IMP(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication
`define FFCI_ASSERT_NXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

@@ design/ffci_pkg.sv @@
// ----------------------------------------------------------------------------
// ffci_pkg
// Types and constants shared by the froxel fog column integrator.
// ----------------------------------------------------------------------------
package ffci_pkg;

	localparam int EXT_W   = 24;
	localparam int INS_W   = 24;
	localparam int THK_W   = 24;
	localparam int SUM_W   = 32;
	localparam int TRANS_W = 17;
	localparam int FLOOR_W = 16;
	localparam int OD_W    = 40;
	localparam int X_W     = 37;
	localparam int K_W     = 6;
	localparam int DIV_N_W = 33;
	localparam int DIV_D_W = 24;
	localparam int A_W     = 25;
	localparam int C_W     = 42;

	localparam logic [FLOOR_W-1:0] FLOOR_RESET = 16'd7;
	localparam logic [31:0]        LN2_Q32     = 32'd2977044472;
	// floor(2^52 / LN2_Q32): od * K_RECIP >> 36 is k or k - 1
	localparam logic [20:0]        K_RECIP     = 21'd1512775;
	localparam logic [32:0]        ONE_Q32     = 33'h1_0000_0000;
	localparam logic [TRANS_W-1:0] ONE_Q16     = 17'h1_0000;
	localparam logic [OD_W-1:0]    DEEP_LIMIT  = 40'd2097152;
	localparam logic [3:0]         SERIES_TERMS = 4'd12;
	localparam int                 QUEUE_DEPTH_DEFAULT = 2;

	typedef struct packed {
		logic             column_start;
		logic [EXT_W-1:0] extinction;
		logic [INS_W-1:0] inscatter_red;
		logic [INS_W-1:0] inscatter_green;
		logic [INS_W-1:0] inscatter_blue;
		logic [THK_W-1:0] slice_thickness;
	} in_beat_t;

	typedef struct packed {
		logic [SUM_W-1:0]   sum_red;
		logic [SUM_W-1:0]   sum_green;
		logic [SUM_W-1:0]   sum_blue;
		logic [TRANS_W-1:0] light_passing;
	} out_beat_t;

	typedef struct packed {
		logic               column_start;
		logic [INS_W-1:0]   ins_red;
		logic [INS_W-1:0]   ins_green;
		logic [INS_W-1:0]   ins_blue;
		logic [DIV_N_W-1:0] factor;
		logic [TRANS_W-1:0] t16;
	} slice_t;

	typedef struct packed {
		logic               start;
		logic [DIV_N_W-1:0] dividend;
		logic [DIV_D_W-1:0] divisor;
	} div_req_t;

endpackage

@@ design/ffci_div.sv @@
// ----------------------------------------------------------------------------
// ffci_div
// Radix-2 restoring divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module ffci_div import ffci_pkg::*; (
	input  logic               clk,
	input  logic               arst_n,
	input  div_req_t           req,
	output logic               done,
	output logic [DIV_N_W-1:0] quotient
);

	localparam int CNT_W = $clog2(DIV_N_W + 1);

	logic [CNT_W-1:0]   cnt_q;
	logic               done_q;
	logic [DIV_D_W-1:0] rem_q;
	logic [DIV_N_W-1:0] num_q;
	logic [DIV_D_W-1:0] den_q;
	logic [DIV_D_W:0]   trial;
	logic [DIV_D_W:0]   rem_next;
	logic               ge;

	assign trial    = {rem_q, num_q[DIV_N_W-1]};
	assign ge       = trial >= {1'b0, den_q};
	assign rem_next = ge ? trial - {1'b0, den_q} : trial;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q  <= '0;
			done_q <= 1'b0;
		end else if (req.start) begin
			cnt_q  <= CNT_W'(DIV_N_W);
			done_q <= 1'b0;
		end else if (cnt_q != '0) begin
			cnt_q  <= cnt_q - 1'b1;
			done_q <= cnt_q == CNT_W'(1);
		end else begin
			done_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (req.start) begin
			rem_q <= '0;
			num_q <= req.dividend;
			den_q <= req.divisor;
		end else if (cnt_q != '0) begin
			rem_q <= rem_next[DIV_D_W-1:0];
			num_q <= {num_q[DIV_N_W-2:0], ge};
		end
	end

	assign done     = done_q;
	assign quotient = num_q;

endmodule

@@ design/ffci_front.sv @@
// ----------------------------------------------------------------------------
// ffci_front
// Accepts slices, computes slice transmittance and integration factor.
// ----------------------------------------------------------------------------
module ffci_front import ffci_pkg::*; (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_ready,
	input  in_beat_t           in_data,
	input  logic [FLOOR_W-1:0] ext_floor,
	output logic               push,
	output slice_t             push_data,
	input  logic               full
);

	localparam logic [3:0] F_IDLE  = 4'd0;
	localparam logic [3:0] F_MUL   = 4'd1;
	localparam logic [3:0] F_RED   = 4'd2;
	localparam logic [3:0] F_KDIV  = 4'd3;
	localparam logic [3:0] F_SMUL  = 4'd4;
	localparam logic [3:0] F_SGO   = 4'd5;
	localparam logic [3:0] F_SWAIT = 4'd6;
	localparam logic [3:0] F_SHIFT = 4'd7;
	localparam logic [3:0] F_FACT  = 4'd8;
	localparam logic [3:0] F_FWAIT = 4'd9;
	localparam logic [3:0] F_PUSH  = 4'd10;
	localparam logic [3:0] F_KFIX  = 4'd11;

	logic [3:0]         state_q;
	in_beat_t           item_q;
	logic [OD_W-1:0]    od_q;
	logic [X_W-1:0]     x_q;
	logic [K_W-1:0]     k_q;
	logic [32:0]        term_q;
	logic [32:0]        sum_q;
	logic [3:0]         n_q;
	logic [63:0]        prod_q;
	logic [64:0]        rprod_q;
	logic [32:0]        t32_q;
	logic [32:0]        factor_q;

	logic [47:0]        od_prod;
	logic [41:0]        k_prod;
	logic [X_W-1:0]     k_ln2;
	logic [32:0]        recip;
	logic [5:0]         rsh;
	logic [32:0]        series_q;
	logic               use_div;
	logic [32:0]        t32_round;
	div_req_t           div_req;
	logic               div_done;
	logic [DIV_N_W-1:0] div_q;

	assign od_prod   = 48'(item_q.extinction) * 48'(item_q.slice_thickness);
	assign k_prod    = 42'(od_q[20:0]) * 42'(K_RECIP);
	assign k_ln2     = X_W'(k_q) * X_W'(LN2_Q32);
	assign series_q  = 33'(rprod_q >> rsh);
	assign use_div   = item_q.extinction > EXT_W'(ext_floor);
	assign t32_round = t32_q + 33'd32768;
	assign in_ready  = state_q == F_IDLE;
	assign push      = (state_q == F_PUSH) && !full;

	// ceil(2^s / n) with s = 32 + ceil(log2 n): exact for 32-bit dividends
	always_comb begin
		case (n_q)
			4'd1:    begin recip = 33'd4294967296; rsh = 6'd32; end
			4'd2:    begin recip = 33'd4294967296; rsh = 6'd33; end
			4'd3:    begin recip = 33'd5726623062; rsh = 6'd34; end
			4'd4:    begin recip = 33'd4294967296; rsh = 6'd34; end
			4'd5:    begin recip = 33'd6871947674; rsh = 6'd35; end
			4'd6:    begin recip = 33'd5726623062; rsh = 6'd35; end
			4'd7:    begin recip = 33'd4908534053; rsh = 6'd35; end
			4'd8:    begin recip = 33'd4294967296; rsh = 6'd35; end
			4'd9:    begin recip = 33'd7635497416; rsh = 6'd36; end
			4'd10:   begin recip = 33'd6871947674; rsh = 6'd36; end
			4'd11:   begin recip = 33'd6247225158; rsh = 6'd36; end
			4'd12:   begin recip = 33'd5726623062; rsh = 6'd36; end
			default: begin recip = 33'd4294967296; rsh = 6'd32; end
		endcase
	end

	always_comb begin
		div_req = '0;
		if (state_q == F_FACT && use_div) begin
			div_req.start    = 1'b1;
			div_req.dividend = ONE_Q32 - t32_q;
			div_req.divisor  = item_q.extinction;
		end
	end

	ffci_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.req      (div_req),
		.done     (div_done),
		.quotient (div_q)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= F_IDLE;
		end else begin
			unique case (state_q)
				F_IDLE: if (in_valid) state_q <= F_MUL;
				F_MUL: state_q <= F_RED;
				F_RED: state_q <= (od_q >= DEEP_LIMIT) ? F_FACT : F_KDIV;
				F_KDIV: state_q <= F_KFIX;
				F_KFIX: state_q <= F_SMUL;
				F_SMUL: state_q <= F_SGO;
				F_SGO: state_q <= F_SWAIT;
				F_SWAIT: state_q <= (n_q == SERIES_TERMS) ? F_SHIFT : F_SMUL;
				F_SHIFT: state_q <= F_FACT;
				F_FACT: state_q <= use_div ? F_FWAIT : F_PUSH;
				F_FWAIT: if (div_done) state_q <= F_PUSH;
				F_PUSH: if (!full) state_q <= F_IDLE;
				default: state_q <= F_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		unique case (state_q)
			F_IDLE: if (in_valid) item_q <= in_data;
			F_MUL: od_q <= od_prod[47:8];
			F_RED: begin
				t32_q <= '0;
				x_q   <= {od_q[20:0], 16'd0};
				k_q   <= k_prod[41:36];
			end
			F_KDIV: x_q <= x_q - k_ln2;
			F_KFIX: begin
				if (x_q >= X_W'(LN2_Q32)) begin
					x_q <= x_q - X_W'(LN2_Q32);
					k_q <= k_q + 1'b1;
				end
				term_q <= ONE_Q32;
				sum_q  <= ONE_Q32;
				n_q    <= 4'd1;
			end
			F_SMUL: prod_q <= 64'(term_q * x_q[31:0]);
			F_SGO: rprod_q <= 65'(prod_q[63:32]) * 65'(recip);
			F_SWAIT: begin
				term_q <= series_q;
				sum_q  <= n_q[0] ? sum_q - series_q : sum_q + series_q;
				n_q    <= n_q + 1'b1;
			end
			F_SHIFT: t32_q <= (k_q >= K_W'(33)) ? '0 : sum_q >> k_q;
			F_FACT: factor_q <= {1'b0, item_q.slice_thickness, 8'd0};
			F_FWAIT: if (div_done) factor_q <= div_q;
			default: ;
		endcase
	end

	always_comb begin
		push_data.column_start = item_q.column_start;
		push_data.ins_red      = item_q.inscatter_red;
		push_data.ins_green    = item_q.inscatter_green;
		push_data.ins_blue     = item_q.inscatter_blue;
		push_data.factor       = factor_q;
		push_data.t16          = t32_round[32:16];
	end

endmodule

@@ design/ffci_fifo.sv @@
// ----------------------------------------------------------------------------
// ffci_fifo
// Short slice queue between the front and back halves.
// ----------------------------------------------------------------------------
module ffci_fifo import ffci_pkg::*; #(
	parameter int DEPTH = QUEUE_DEPTH_DEFAULT
) (
	input  logic   clk,
	input  logic   arst_n,
	input  logic   push,
	input  slice_t push_data,
	output logic   full,
	input  logic   pop,
	output slice_t pop_data,
	output logic   empty
);

	localparam int PTR_W = $clog2(DEPTH);
	localparam int CNT_W = $clog2(DEPTH + 1);

	slice_t           mem_q [DEPTH];
	logic [PTR_W-1:0] wr_ptr_q;
	logic [PTR_W-1:0] rd_ptr_q;
	logic [CNT_W-1:0] cnt_q;

	assign full     = cnt_q == CNT_W'(DEPTH);
	assign empty    = cnt_q == '0;
	assign pop_data = mem_q[rd_ptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (push) wr_ptr_q <= (wr_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			if (pop) rd_ptr_q <= (rd_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			if (push && !pop) cnt_q <= cnt_q + 1'b1;
			else if (pop && !push) cnt_q <= cnt_q - 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (push) mem_q[wr_ptr_q] <= push_data;
	end

endmodule

@@ design/ffci_back.sv @@
// ----------------------------------------------------------------------------
// ffci_back
// Accumulates weighted inscatter and transmittance, drives result beats.
// ----------------------------------------------------------------------------
module ffci_back import ffci_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	output logic      pop,
	input  slice_t    pop_data,
	input  logic      empty,
	output logic      out_valid,
	input  logic      out_ready,
	output out_beat_t out_data
);

	localparam logic [2:0] B_IDLE = 3'd0;
	localparam logic [2:0] B_MA   = 3'd1;
	localparam logic [2:0] B_MC   = 3'd2;
	localparam logic [2:0] B_ADD  = 3'd3;
	localparam logic [2:0] B_PF   = 3'd4;
	localparam logic [2:0] B_OUT  = 3'd5;

	logic [2:0]         state_q;
	slice_t             item_q;
	logic [1:0]         col_q;
	logic [SUM_W-1:0]   acc_q [3];
	logic [TRANS_W-1:0] pf_q;
	logic [A_W-1:0]     a_q;
	logic [C_W-1:0]     c_q;
	logic               out_valid_q;
	out_beat_t          out_q;

	logic [INS_W-1:0]   ins_sel;
	logic [40:0]        mul_a;
	logic [57:0]        mul_c;
	logic [C_W:0]       acc_sum;
	logic [SUM_W-1:0]   acc_sat;
	logic [33:0]        pf_prod;
	logic               load;

	always_comb begin
		case (col_q)
			2'd0:    ins_sel = item_q.ins_red;
			2'd1:    ins_sel = item_q.ins_green;
			default: ins_sel = item_q.ins_blue;
		endcase
	end

	assign mul_a   = 41'(pf_q) * 41'(ins_sel);
	assign mul_c   = 58'(a_q) * 58'(item_q.factor);
	assign acc_sum = (C_W + 1)'(acc_q[col_q]) + (C_W + 1)'(c_q);
	assign acc_sat = (acc_sum[C_W:SUM_W] != '0) ? '1 : acc_sum[SUM_W-1:0];
	assign pf_prod = 34'(pf_q) * 34'(item_q.t16) + 34'd32768;
	assign pop     = (state_q == B_IDLE) && !empty;
	assign load    = (state_q == B_OUT) && (!out_valid_q || out_ready);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= B_IDLE;
			col_q       <= '0;
			acc_q[0]    <= '0;
			acc_q[1]    <= '0;
			acc_q[2]    <= '0;
			pf_q        <= ONE_Q16;
			out_valid_q <= 1'b0;
		end else begin
			if (load) out_valid_q <= 1'b1;
			else if (out_ready) out_valid_q <= 1'b0;
			unique case (state_q)
				B_IDLE: begin
					if (!empty) begin
						col_q <= '0;
						if (pop_data.column_start) begin
							acc_q[0] <= '0;
							acc_q[1] <= '0;
							acc_q[2] <= '0;
							pf_q     <= ONE_Q16;
						end
						state_q <= B_MA;
					end
				end
				B_MA: state_q <= B_MC;
				B_MC: state_q <= B_ADD;
				B_ADD: begin
					acc_q[col_q] <= acc_sat;
					col_q        <= col_q + 1'b1;
					state_q      <= (col_q == 2'd2) ? B_PF : B_MA;
				end
				B_PF: begin
					pf_q    <= pf_prod[32:16];
					state_q <= B_OUT;
				end
				B_OUT: if (load) state_q <= B_IDLE;
				default: state_q <= B_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (pop) item_q <= pop_data;
		if (state_q == B_MA) a_q <= mul_a[40:16];
		if (state_q == B_MC) c_q <= mul_c[57:16];
		if (load) begin
			out_q.sum_red       <= acc_q[0];
			out_q.sum_green     <= acc_q[1];
			out_q.sum_blue      <= acc_q[2];
			out_q.light_passing <= pf_q;
		end
	end

	assign out_valid = out_valid_q;
	assign out_data  = out_q;

endmodule

@@ design/froxel_fog_column_integrator.sv @@
// Froxel fog column integrator: slices of one screen column go in front to back,
// one beat each, and every slice returns one beat with the running RGB fog sums
// and the transmittance behind it. In the front half each of the twelve exp series
// terms runs through multiply, reciprocal-multiply and accumulate states, and the
// integration factor takes a one-bit-per-cycle divide of a 33-bit quotient; deep
// slices skip the series and low-extinction slices skip the divide. The back half
// works each colour in turn and overlaps the next slice through a short queue.
// ----------------------------------------------------------------------------
// froxel_fog_column_integrator
// Top level: floor register, front half, slice queue, back half.
// ----------------------------------------------------------------------------
`include "froxel_fog_column_integrator_assert.svh"

module froxel_fog_column_integrator import ffci_pkg::*; #(
	parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEFAULT
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_ready,
	input  in_beat_t           in_data,
	output logic               out_valid,
	input  logic               out_ready,
	output out_beat_t          out_data,
	input  logic               cfg_valid,
	output logic               cfg_ready,
	input  logic [FLOOR_W-1:0] cfg_data
);

	logic [FLOOR_W-1:0] floor_q;
	logic               q_push;
	logic               q_pop;
	logic               q_full;
	logic               q_empty;
	slice_t             q_wdata;
	slice_t             q_rdata;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			floor_q <= FLOOR_RESET;
		end else if (cfg_valid) begin
			floor_q <= cfg_data;
		end
	end

	ffci_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.in_data   (in_data),
		.ext_floor (floor_q),
		.push      (q_push),
		.push_data (q_wdata),
		.full      (q_full)
	);

	ffci_fifo #(
		.DEPTH (QUEUE_DEPTH)
	) u_fifo (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (q_push),
		.push_data (q_wdata),
		.full      (q_full),
		.pop       (q_pop),
		.pop_data  (q_rdata),
		.empty     (q_empty)
	);

	ffci_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.pop       (q_pop),
		.pop_data  (q_rdata),
		.empty     (q_empty),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.out_data  (out_data)
	);

	`FFCI_ASSERT_IMP(a_push_not_full, q_push, !q_full, "slice pushed into full queue")
	`FFCI_ASSERT_IMP(a_pop_not_empty, q_pop, !q_empty, "slice popped from empty queue")
	`FFCI_ASSERT_IMP(a_trans_range, out_valid, out_data.light_passing <= ONE_Q16, "passing above one")

endmodule

@@ tb/tb.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Froxel fog column integrator testbench
// Drives slices through the valid/ready input channel and checks every
// output beat against an in-bench fixed-point model of the Beer-Lambert
// fog integration. The floor register is written between phases.
// ----------------------------------------------------------------------------
module tb;
	import ffci_pkg::*;

	localparam int DRAIN_CYCLES = 600;

	logic               clk;
	logic               arst_n;
	logic               in_valid;
	logic               in_ready;
	in_beat_t           in_data;
	logic               out_valid;
	logic               out_ready;
	out_beat_t          out_data;
	logic               cfg_valid;
	logic               cfg_ready;
	logic [FLOOR_W-1:0] cfg_data;

	froxel_fog_column_integrator i_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.in_data   (in_data),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.out_data  (out_data),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_data  (cfg_data)
	);

	// model state
	longint unsigned floor_q16;
	longint unsigned fog_red, fog_green, fog_blue, transmit_q16;
	out_beat_t       pending_sums[$];
	int              send_idle_pct;
	int              recv_stall_pct;
	int              mismatches = 0;

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	initial begin
		#50ms;
		$display("FAILED: results differ");
		$finish;
	end

	function automatic longint unsigned slice_exp_q32(longint unsigned od);
		longint unsigned x, k, r, term, acc;
		if (od >= 64'(DEEP_LIMIT))
			return 0;
		x = od << 16;
		k = x / 64'(LN2_Q32);
		r = x - k * 64'(LN2_Q32);
		term = 64'(ONE_Q32);
		acc = 64'(ONE_Q32);
		for (int n = 1; n <= 12; n++) begin
			term = ((term * r) >> 32) / n;
			if (n % 2 == 1)
				acc = acc - term;
			else
				acc = acc + term;
		end
		return acc >> k;
	endfunction

	function automatic longint unsigned add_fog(longint unsigned acc, longint unsigned ins,
			longint unsigned factor);
		longint unsigned a, s;
		a = (transmit_q16 * ins) >> 16;
		s = acc + ((a * factor) >> 16);
		return (s > 64'hFFFF_FFFF) ? 64'hFFFF_FFFF : s;
	endfunction

	function automatic out_beat_t integrate_slice(in_beat_t b);
		longint unsigned ext, thick, od, t32, t16, factor;
		out_beat_t o;
		ext = 64'(b.extinction);
		thick = 64'(b.slice_thickness);
		if (b.column_start) begin
			fog_red = 0;
			fog_green = 0;
			fog_blue = 0;
			transmit_q16 = 64'(ONE_Q16);
		end
		od = (ext * thick) >> 8;
		t32 = slice_exp_q32(od);
		t16 = (t32 + 32768) >> 16;
		if (ext > floor_q16)
			factor = (64'(ONE_Q32) - t32) / ext;
		else
			factor = thick << 8;
		fog_red = add_fog(fog_red, 64'(b.inscatter_red), factor);
		fog_green = add_fog(fog_green, 64'(b.inscatter_green), factor);
		fog_blue = add_fog(fog_blue, 64'(b.inscatter_blue), factor);
		transmit_q16 = (transmit_q16 * t16 + 32768) >> 16;
		o.sum_red = fog_red[31:0];
		o.sum_green = fog_green[31:0];
		o.sum_blue = fog_blue[31:0];
		o.light_passing = transmit_q16[16:0];
		return o;
	endfunction

	always @(negedge clk)
		out_ready <= arst_n && ($urandom_range(99) >= recv_stall_pct);

	always @(posedge clk) begin
		out_beat_t want;
		if (arst_n && out_valid && out_ready) begin
			if (pending_sums.size() == 0) begin
				mismatches++;
				if (mismatches <= 10)
					$display("unexpected beat %p", out_data);
			end else begin
				want = pending_sums.pop_front();
				if (out_data.sum_red !== want.sum_red || out_data.sum_green !== want.sum_green
						|| out_data.sum_blue !== want.sum_blue
						|| out_data.light_passing !== want.light_passing) begin
					mismatches++;
					if (mismatches <= 10)
						$display("mismatch: expected %p actual %p", want, out_data);
				end
			end
		end
	end

	task automatic send_slice(in_beat_t b);
		@(negedge clk);
		while ($urandom_range(99) < send_idle_pct) begin
			in_valid = 1'b0;
			@(negedge clk);
		end
		in_valid = 1'b1;
		in_data = b;
		do @(posedge clk); while (!in_ready);
		pending_sums.push_back(integrate_slice(b));
	endtask

	task automatic wait_drained();
		@(negedge clk);
		in_valid = 1'b0;
		while (pending_sums.size() != 0)
			@(negedge clk);
		repeat (DRAIN_CYCLES) @(negedge clk);
	endtask

	task automatic write_floor(logic [FLOOR_W-1:0] value);
		wait_drained();
		cfg_valid = 1'b1;
		cfg_data = value;
		do @(posedge clk); while (!cfg_ready);
		floor_q16 = 64'(value);
		@(negedge clk);
		cfg_valid = 1'b0;
	endtask

	function automatic in_beat_t make_slice(logic first, logic [23:0] ext, logic [23:0] r,
			logic [23:0] g, logic [23:0] bl, logic [23:0] thick);
		in_beat_t b;
		b.column_start = first;
		b.extinction = ext;
		b.inscatter_red = r;
		b.inscatter_green = g;
		b.inscatter_blue = bl;
		b.slice_thickness = thick;
		return b;
	endfunction

	function automatic logic [23:0] rand_field();
		return 24'($urandom) >> $urandom_range(23);
	endfunction

	// extremes, continuation from reset state, deep slices and saturation
	task automatic test_directed();
		send_slice(make_slice(1'b0, 24'd0, 24'd0, 24'd0, 24'd0, 24'd0));
		send_slice(make_slice(1'b0, 24'h01_0000, 24'h01_0000, 24'h02_0000, 24'h03_0000,
			24'h00_0100));
		send_slice(make_slice(1'b1, 24'd7, 24'hFF_FFFF, 24'hFF_FFFF, 24'hFF_FFFF, 24'hFF_FFFF));
		send_slice(make_slice(1'b0, 24'd8, 24'hFF_FFFF, 24'h00_0001, 24'h80_0000, 24'hFF_FFFF));
		send_slice(make_slice(1'b1, 24'hFF_FFFF, 24'hFF_FFFF, 24'hFF_FFFF, 24'hFF_FFFF,
			24'hFF_FFFF));
		send_slice(make_slice(1'b1, 24'h20_0000, 24'h10_0000, 24'h10_0000, 24'h10_0000,
			24'h00_0100));
		send_slice(make_slice(1'b0, 24'h1F_FFFF, 24'h55_5555, 24'hAA_AAAA, 24'h12_3456,
			24'h00_0100));
		send_slice(make_slice(1'b1, 24'h00_8000, 24'h01_0000, 24'h01_0000, 24'h01_0000,
			24'h00_0080));
		send_slice(make_slice(1'b0, 24'h00_8000, 24'h01_0000, 24'h01_0000, 24'h01_0000,
			24'h00_0080));
		send_slice(make_slice(1'b0, 24'hFF_FFFF, 24'd0, 24'd0, 24'd0, 24'd1));
	endtask

	task automatic test_floor_extremes();
		write_floor(16'd0);
		send_slice(make_slice(1'b1, 24'd0, 24'h01_0000, 24'h01_0000, 24'h01_0000, 24'h00_0100));
		send_slice(make_slice(1'b0, 24'd1, 24'h01_0000, 24'h01_0000, 24'h01_0000, 24'h00_0100));
		write_floor(16'hFFFF);
		send_slice(make_slice(1'b1, 24'h00_FFFF, 24'h01_0000, 24'h01_0000, 24'h01_0000,
			24'h00_0200));
		send_slice(make_slice(1'b0, 24'h01_0000, 24'h01_0000, 24'h01_0000, 24'h01_0000,
			24'h00_0200));
		send_slice(make_slice(1'b0, 24'hFF_FFFF, 24'hFF_FFFF, 24'hFF_FFFF, 24'hFF_FFFF, 24'd0));
	endtask

	task automatic test_random_columns(int count);
		int left;
		left = 0;
		for (int i = 0; i < count; i++) begin
			in_beat_t b;
			if (left == 0)
				left = $urandom_range(40, 1);
			b.column_start = (left == 1) ? 1'b0 : 1'b0;
			b.column_start = ($urandom_range(99) < 3) ? 1'b0 : (left == 40 || i == 0);
			b.extinction = ($urandom_range(3) == 0) ? 24'($urandom_range(16)) : rand_field();
			b.inscatter_red = rand_field();
			b.inscatter_green = rand_field();
			b.inscatter_blue = rand_field();
			b.slice_thickness = rand_field();
			if ($urandom_range(7) == 0)
				b.column_start = 1'b1;
			left--;
			if (left == 0)
				left = 0;
			send_slice(b);
		end
	endtask

	initial begin
		arst_n = 1'b0;
		in_valid = 1'b0;
		in_data = '0;
		cfg_valid = 1'b0;
		cfg_data = '0;
		send_idle_pct = 34;
		recv_stall_pct = 76;
		floor_q16 = 64'(FLOOR_RESET);
		fog_red = 0;
		fog_green = 0;
		fog_blue = 0;
		transmit_q16 = 64'(ONE_Q16);
		repeat (12) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		test_directed();
		test_floor_extremes();
		write_floor(16'($urandom));
		test_random_columns(400);
		send_idle_pct = 76;
		recv_stall_pct = 34;
		write_floor(16'($urandom_range(64)));
		test_random_columns(400);
		send_idle_pct = 0;
		recv_stall_pct = 0;
		write_floor(FLOOR_RESET);
		test_random_columns(400);
		wait_drained();

		if (mismatches == 0)
			$display("PASSED: all results match");
		else
			$display("FAILED: results differ");
		$finish;
	end

endmodule
